/* src/csw_pkg.sv */
// Shared types and constants for the cube shell walk address block.
// Used by the controller, the datapath and the top level; depends on nothing.
package csw_pkg;

  localparam int COORD_W = 6;   // signed cell offset
  localparam int LAYER_W = 6;   // shell number, 0..32
  localparam int STEP_W  = 18;  // remaining step count
  localparam int HALF_W  = 5;   // half extent register
  localparam int SIDE_W  = 7;   // store side 2H+3
  localparam int POS_W   = 6;   // padded coordinate x+H+1
  localparam int ROW_W   = 13;  // px*S + py
  localparam int INDEX_W = 19;  // linear store index

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture an accepted word
    logic fail;   // mark the query as not found
    logic step;   // advance one cell in shell order
    logic mul1;   // row product px*S + py
    logic mul2;   // full index row*S + pz
    logic push;   // move the result into the output register
  } csw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;      // zero steps or start shell beyond H
    logic steps_zero;  // no steps left
    logic last_step;   // exactly one step left
    logic exit_walk;   // next step would leave the outer shell
    logic out_free;    // output register can take a result
  } csw_status_t;

endpackage

/* src/csw_ctrl.sv */
// Controller state machine for the cube shell walk address block.
// Depends on csw_pkg for the command and status structs.
module csw_ctrl import csw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  csw_status_t status,
  output csw_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_WALK = 6'b000100,
    S_MUL1 = 6'b001000,
    S_MUL2 = 6'b010000,
    S_OUT  = 6'b100000
  } csw_state_t;

  csw_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.reject) begin
          cmd.fail  = 1'b1;
          state_nxt = S_OUT;
        end else if (status.steps_zero) begin
          state_nxt = S_MUL1;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (status.exit_walk) begin
          cmd.fail  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.step = 1'b1;
          if (status.last_step) begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/csw_dp.sv */
// Datapath for the cube shell walk address block: walk registers, index
// multiplier steps and the output register. Depends on csw_pkg.
module csw_dp import csw_pkg::*; #(
  parameter int MAX_HALF_EXTENT = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [HALF_W-1:0]         half_extent,
  input  logic                      in_from_centre,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_start_z,
  input  logic [STEP_W-1:0]         in_step_count,
  input  csw_cmd_t                  cmd,
  output csw_status_t               status,
  input  logic                      out_tready,
  output logic                      out_valid,
  output logic                      out_found,
  output logic signed [COORD_W-1:0] out_cell_x,
  output logic signed [COORD_W-1:0] out_cell_y,
  output logic signed [COORD_W-1:0] out_cell_z,
  output logic [INDEX_W-1:0]        out_cell_index
);

  localparam logic [7:0]        MAX_H8 = 8'(MAX_HALF_EXTENT);
  localparam logic [HALF_W-1:0] MAX_H5 = HALF_W'(MAX_HALF_EXTENT);

  logic signed [COORD_W-1:0] x_r, y_r, z_r;
  logic [LAYER_W-1:0]        layer_r;
  logic [STEP_W-1:0]         steps_r;
  logic [HALF_W-1:0]         h_r;
  logic                      zero_r;
  logic                      fail_r;
  logic [ROW_W-1:0]          row_r;
  logic [INDEX_W-1:0]        index_r;

  logic                      out_valid_r;
  logic                      out_found_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [INDEX_W-1:0]        out_index_r;

  // Start cell and its shell number.
  logic signed [COORD_W-1:0] sx, sy, sz;
  logic [LAYER_W-1:0]        ax, ay, az, start_layer;

  always_comb begin
    if (in_from_centre) begin
      sx = '0;
      sy = '0;
      sz = '0;
    end else begin
      sx = in_start_x;
      sy = in_start_y;
      sz = in_start_z;
    end
    ax = sx[COORD_W-1] ? LAYER_W'(-sx) : LAYER_W'(sx);
    ay = sy[COORD_W-1] ? LAYER_W'(-sy) : LAYER_W'(sy);
    az = sz[COORD_W-1] ? LAYER_W'(-sz) : LAYER_W'(sz);
    start_layer = ax;
    if (ay > start_layer) start_layer = ay;
    if (az > start_layer) start_layer = az;
  end

  // Shell-order step on seven-bit signed values.
  logic signed [COORD_W:0] x7, y7, z7, lay7, nlay7;
  logic                    z_below, y_below, x_below, on_face;
  logic [LAYER_W-1:0]      layer_inc;

  always_comb begin
    x7        = {x_r[COORD_W-1], x_r};
    y7        = {y_r[COORD_W-1], y_r};
    z7        = {z_r[COORD_W-1], z_r};
    lay7      = {1'b0, layer_r};
    nlay7     = -lay7;
    z_below   = (z7 < lay7);
    y_below   = (y7 < lay7);
    x_below   = (x7 < lay7);
    on_face   = (x7 == lay7) || (x7 == nlay7) || (y7 == lay7) || (y7 == nlay7);
    layer_inc = layer_r + LAYER_W'(1);
  end

  // Padded coordinates and store side.
  logic [SIDE_W-1:0]   side;
  logic [POS_W-1:0]    px, py, pz;
  logic [ROW_W-1:0]    row_nxt;
  logic [ROW_W+SIDE_W-1:0] full_prod;

  always_comb begin
    side      = {1'b0, h_r, 1'b0} + SIDE_W'(3);
    px        = POS_W'(x7 + $signed({2'b0, h_r}) + 7'sd1);
    py        = POS_W'(y7 + $signed({2'b0, h_r}) + 7'sd1);
    pz        = POS_W'(z7 + $signed({2'b0, h_r}) + 7'sd1);
    row_nxt   = ROW_W'(px) * ROW_W'(side) + ROW_W'(py);
    full_prod = row_r * side;
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= sx;
      y_r     <= sy;
      z_r     <= sz;
      layer_r <= start_layer;
      zero_r  <= (in_step_count == '0);
      steps_r <= (in_from_centre && in_step_count != '0) ?
                 in_step_count - STEP_W'(1) : in_step_count;
      h_r     <= ({3'b0, half_extent} > MAX_H8) ? MAX_H5 : half_extent;
    end else if (cmd.step) begin
      steps_r <= steps_r - STEP_W'(1);
      if (z_below) begin
        z_r <= on_face ? z_r + COORD_W'(1) : COORD_W'(lay7);
      end else if (y_below) begin
        y_r <= y_r + COORD_W'(1);
        z_r <= COORD_W'(nlay7);
      end else if (x_below) begin
        x_r <= x_r + COORD_W'(1);
        y_r <= COORD_W'(nlay7);
        z_r <= COORD_W'(nlay7);
      end else begin
        layer_r <= layer_inc;
        x_r     <= -COORD_W'(layer_inc);
        y_r     <= -COORD_W'(layer_inc);
        z_r     <= -COORD_W'(layer_inc);
      end
    end
  end

  // Not-found flag, cleared per query.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_r <= 1'b0;
    end else if (cmd.load) begin
      fail_r <= 1'b0;
    end else if (cmd.fail) begin
      fail_r <= 1'b1;
    end
  end

  // Index multiply in two registered steps.
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      row_r <= row_nxt;
    end
    if (cmd.mul2) begin
      index_r <= INDEX_W'(full_prod) + INDEX_W'(pz);
    end
  end

  // Output register; frees the walk side while a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_found_r <= !fail_r;
      out_x_r     <= fail_r ? '0 : x_r;
      out_y_r     <= fail_r ? '0 : y_r;
      out_z_r     <= fail_r ? '0 : z_r;
      out_index_r <= fail_r ? '0 : index_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.reject     = zero_r || (layer_r > {1'b0, h_r});
    status.steps_zero = (steps_r == '0);
    status.last_step  = (steps_r == STEP_W'(1));
    status.exit_walk  = !z_below && !y_below && !x_below && (layer_r == {1'b0, h_r});
    status.out_free   = !out_valid_r || out_tready;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_cell_x     = out_x_r;
  assign out_cell_y     = out_y_r;
  assign out_cell_z     = out_z_r;
  assign out_cell_index = out_index_r;

endmodule

/* src/cube_shell_walk_address.sv */
// Top level of the cube shell walk address block: half extent register,
// controller and datapath. Depends on csw_pkg, csw_ctrl and csw_dp.
//
//   channel  | direction | tdata / tuser contents
//   ---------+-----------+--------------------------------------------------
//   in_      | slave     | tdata: start_x, start_y, start_z, step_count
//            |           | tuser: from_centre
//   out_     | master    | tdata: cell_x, cell_y, cell_z, cell_index
//            |           | tuser: found
//   cfg_     | write     | cfg_wr_data: half_extent, taken when cfg_wr_en
//
// After acceptance, a found result word passes through the check state, the walk
// states that take one cell per walk cycle, the row and index multiply steps and
// the output handoff. The next word is taken in the idle state that follows the
// handoff. A rejected query goes from the check straight to the handoff; a walk
// that leaves the outer shell goes from the walk state to the handoff.
// Reset (rst_n low, synchronous) sets half_extent to 4 and empties the
// output. A stalled output holds its word and blocks only the next handoff.
module cube_shell_walk_address import csw_pkg::*; #(
  parameter int MAX_HALF_EXTENT = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input word.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // start_x[5:0], start_y[11:6],
                                        // start_z[17:12], step_count[35:18]
  input  logic              in_tuser,   // from_centre[0]
  // Result word.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // cell_x[5:0], cell_y[11:6],
                                        // cell_z[17:12], cell_index[36:18]
  output logic              out_tuser,  // found[0]
  // Configuration.
  input  logic              cfg_wr_en,
  input  logic [HALF_W-1:0] cfg_wr_data
);

  logic [HALF_W-1:0]         half_extent_r;
  csw_cmd_t                  cmd;
  csw_status_t               status;
  logic                      found;
  logic signed [COORD_W-1:0] cell_x, cell_y, cell_z;
  logic [INDEX_W-1:0]        cell_index;

  // Half extent register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_extent_r <= HALF_W'(4);
    end else if (cfg_wr_en) begin
      half_extent_r <= cfg_wr_data;
    end
  end

  csw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  csw_dp #(
    .MAX_HALF_EXTENT (MAX_HALF_EXTENT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .half_extent    (half_extent_r),
    .in_from_centre (in_tuser),
    .in_start_x     (in_tdata[5:0]),
    .in_start_y     (in_tdata[11:6]),
    .in_start_z     (in_tdata[17:12]),
    .in_step_count  (in_tdata[35:18]),
    .cmd            (cmd),
    .status         (status),
    .out_tready     (out_tready),
    .out_valid      (out_tvalid),
    .out_found      (found),
    .out_cell_x     (cell_x),
    .out_cell_y     (cell_y),
    .out_cell_z     (cell_z),
    .out_cell_index (cell_index)
  );

  // Pack the result word.
  assign out_tuser = found;
  assign out_tdata = {3'b000, cell_index, cell_z, cell_y, cell_x};

endmodule

/* src/csw_checker.sv */
// Port-level checks for the cube shell walk address block, bound to the
// top level. Depends only on the top level's ports.
module csw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // A not-found result carries all-zero fields.
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 40'd0)
    else $error("not-found result has nonzero fields");

  // Only one query is in flight: input closes right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a query is in flight");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind cube_shell_walk_address csw_checker u_csw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
